// ===== rtl/crt_pkg.sv =====
package crt_pkg;

   localparam int CMD_BITS    = 2;
   localparam int STATUS_BITS = 3;
   localparam int MAP_BITS    = 16;
   localparam int OWNER_BITS  = 16;
   localparam int SIZE_BITS   = 32;

   localparam logic [CMD_BITS-1:0] CMD_LOOKUP = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_REMOVE = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_MISS    = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_INVALID = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_OVERLAP = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd4;

   localparam logic [OWNER_BITS-1:0] OWNER_NONE  = '0;
   localparam logic [OWNER_BITS-1:0] OWNER_FIRST = 16'd1;
   localparam logic [OWNER_BITS-1:0] OWNER_LAST  = 16'hFFFF;

   // token that walks the cell row
   typedef struct packed {
      logic                  active;
      logic [CMD_BITS-1:0]   cmd;
      logic                  hit;
      logic                  overlap;
      logic                  free_found;
      logic [MAP_BITS-1:0]   map;
      logic [OWNER_BITS-1:0] owner;
   } tok_type;

   // control broadcast to every cell
   typedef struct packed {
      logic                  drop_en;
      logic [OWNER_BITS-1:0] drop_owner;
      logic                  wr_en;
      logic [MAP_BITS-1:0]   wr_map;
      logic [OWNER_BITS-1:0] wr_owner;
   } bcast_type;

endpackage

// ===== rtl/crt_ifs.sv =====
interface crt_req_if #(
   parameter int ADDR_BITS = 48
);
   logic                             valid;
   logic                             ready;
   logic [crt_pkg::CMD_BITS-1:0]     cmd;
   logic [ADDR_BITS-1:0]             address;
   logic [crt_pkg::SIZE_BITS-1:0]    code_bytes;
   logic [crt_pkg::SIZE_BITS-1:0]    last_offset;
   logic                             has_records;
   logic                             group_start;
   logic [crt_pkg::MAP_BITS-1:0]     map_ref;
   logic [crt_pkg::OWNER_BITS-1:0]   owner_to_drop;

   modport source (
      output valid, cmd, address, code_bytes, last_offset, has_records, group_start,
             map_ref, owner_to_drop,
      input  ready
   );
   modport sink (
      input  valid, cmd, address, code_bytes, last_offset, has_records, group_start,
             map_ref, owner_to_drop,
      output ready
   );
endinterface

interface crt_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [crt_pkg::STATUS_BITS-1:0]  status;
   logic [crt_pkg::MAP_BITS-1:0]     found_map;
   logic [crt_pkg::OWNER_BITS-1:0]   owner_id;

   modport source (
      output valid, status, found_map, owner_id,
      input  ready
   );
   modport sink (
      input  valid, status, found_map, owner_id,
      output ready
   );
endinterface

// ===== rtl/code_range_table.sv =====
// channel   | dir | handshake    | payload
// req_bus   | in  | valid/ready  | cmd, address, code_bytes, last_offset, has_records,
//           |     |              | group_start, map_ref, owner_to_drop
// rsp_bus   | out | valid/ready  | status, found_map, owner_id
//
// each command passes from its transfer through the LAUNCH, RUN and FINISH states before the
// next req transfer, while the token walks one cell per cycle down the row of TABLE_ENTRIES cells
// one command at a time; a result waiting on rsp_bus does not block the next req transfer,
// only the commit of the following result
// synchronous reset clears all entries and the owner counter, no clearing pass

module code_range_table #(
   parameter int TABLE_ENTRIES = 64,
   parameter int ADDRESS_BITS  = 48
) (
   input  logic          clock,
   input  logic          reset,
   crt_req_if.sink       req_bus,
   crt_rsp_if.source     rsp_bus
);

   localparam int SLOT_BITS = $clog2(TABLE_ENTRIES);
   localparam int LEN_BITS  = crt_pkg::SIZE_BITS + 1;
   localparam int SUM_BITS  = (ADDRESS_BITS > LEN_BITS ? ADDRESS_BITS : LEN_BITS) + 1;

   typedef enum logic [1:0] {
      IDLE,
      LAUNCH,
      RUN,
      FINISH
   } state_type;

   state_type                          state_ff;
   logic [crt_pkg::CMD_BITS-1:0]       cmd_ff;
   logic [ADDRESS_BITS-1:0]            addr_ff;
   logic [ADDRESS_BITS-1:0]            end_ff;
   logic                               bad_ff;
   logic                               group_ff;
   logic [crt_pkg::MAP_BITS-1:0]       map_ff;
   logic [crt_pkg::OWNER_BITS-1:0]     drop_ff;
   crt_pkg::tok_type                   fin_tok_ff;
   logic [SLOT_BITS-1:0]               fin_slot_ff;
   logic [crt_pkg::OWNER_BITS-1:0]     next_owner_ff;
   logic [crt_pkg::OWNER_BITS-1:0]     open_owner_ff;
   logic                               rsp_valid_ff;
   logic [crt_pkg::STATUS_BITS-1:0]    status_ff;
   logic [crt_pkg::MAP_BITS-1:0]       found_map_ff;
   logic [crt_pkg::OWNER_BITS-1:0]     owner_id_ff;

   logic [LEN_BITS-1:0]                len;
   logic [SUM_BITS-1:0]                sum;
   logic                               req_bad;
   logic                               commit;
   logic                               ins_ok;
   logic                               take_owner;
   logic [crt_pkg::OWNER_BITS-1:0]     ins_owner;
   logic [crt_pkg::STATUS_BITS-1:0]    status_in;
   logic [crt_pkg::MAP_BITS-1:0]       found_map_in;
   logic [crt_pkg::OWNER_BITS-1:0]     owner_id_in;
   crt_pkg::bcast_type                 bcast;
   crt_pkg::tok_type                   launch_tok;
   crt_pkg::tok_type                   tok_chain [0:TABLE_ENTRIES];
   logic [SLOT_BITS-1:0]               slot_chain [0:TABLE_ENTRIES];

   // range end and validity of an insert
   always_comb begin
      if (req_bus.code_bytes != '0) begin
         len = LEN_BITS'(req_bus.code_bytes);
      end else begin
         len = LEN_BITS'(req_bus.last_offset) + LEN_BITS'(1);
      end
      sum     = SUM_BITS'(req_bus.address) + SUM_BITS'(len);
      req_bad = (req_bus.address == '0) || !req_bus.has_records
                || ((sum >> ADDRESS_BITS) != '0);
   end

   assign req_bus.ready = (state_ff == IDLE);

   always_comb begin
      launch_tok        = '0;
      launch_tok.active = (state_ff == LAUNCH);
      launch_tok.cmd    = cmd_ff;
   end

   assign tok_chain[0]  = launch_tok;
   assign slot_chain[0] = '0;

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      crt_cell #(
         .ADDR_BITS (ADDRESS_BITS),
         .SLOT_BITS (SLOT_BITS),
         .INDEX     (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .tok_in   (tok_chain[i]),
         .slot_in  (slot_chain[i]),
         .tok_out  (tok_chain[i+1]),
         .slot_out (slot_chain[i+1]),
         .key_addr (addr_ff),
         .key_end  (end_ff),
         .bcast    (bcast),
         .wr_slot  (fin_slot_ff)
      );
   end

   // result of the finished walk
   always_comb begin
      commit       = (state_ff == FINISH) && (!rsp_valid_ff || rsp_bus.ready);
      take_owner   = group_ff || (open_owner_ff == crt_pkg::OWNER_NONE);
      ins_owner    = take_owner ? next_owner_ff : open_owner_ff;
      ins_ok       = 1'b0;
      status_in    = crt_pkg::ST_OK;
      found_map_in = '0;
      owner_id_in  = '0;
      case (fin_tok_ff.cmd)
         crt_pkg::CMD_LOOKUP: begin
            if (fin_tok_ff.hit) begin
               found_map_in = fin_tok_ff.map;
               owner_id_in  = fin_tok_ff.owner;
            end else begin
               status_in = crt_pkg::ST_MISS;
            end
         end
         crt_pkg::CMD_INSERT: begin
            if (bad_ff) begin
               status_in = crt_pkg::ST_INVALID;
            end else if (fin_tok_ff.overlap) begin
               status_in = crt_pkg::ST_OVERLAP;
            end else if (!fin_tok_ff.free_found) begin
               status_in = crt_pkg::ST_FULL;
            end else begin
               ins_ok      = 1'b1;
               owner_id_in = ins_owner;
            end
         end
         crt_pkg::CMD_REMOVE: begin
            status_in = crt_pkg::ST_OK;
         end
         default: begin
            status_in = crt_pkg::ST_INVALID;
         end
      endcase
   end

   always_comb begin
      bcast.drop_en    = (cmd_ff == crt_pkg::CMD_REMOVE) && (drop_ff != crt_pkg::OWNER_NONE);
      bcast.drop_owner = drop_ff;
      bcast.wr_en      = commit && ins_ok;
      bcast.wr_map     = map_ff;
      bcast.wr_owner   = ins_owner;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         rsp_valid_ff  <= 1'b0;
         next_owner_ff <= crt_pkg::OWNER_FIRST;
         open_owner_ff <= crt_pkg::OWNER_NONE;
      end else begin
         if (rsp_valid_ff && rsp_bus.ready && !commit) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (req_bus.valid) begin
                  cmd_ff   <= req_bus.cmd;
                  addr_ff  <= req_bus.address;
                  end_ff   <= sum[ADDRESS_BITS-1:0];
                  bad_ff   <= req_bad;
                  group_ff <= req_bus.group_start;
                  map_ff   <= req_bus.map_ref;
                  drop_ff  <= req_bus.owner_to_drop;
                  state_ff <= LAUNCH;
               end
            end
            LAUNCH: begin
               state_ff <= RUN;
            end
            RUN: begin
               if (tok_chain[TABLE_ENTRIES].active) begin
                  fin_tok_ff  <= tok_chain[TABLE_ENTRIES];
                  fin_slot_ff <= slot_chain[TABLE_ENTRIES];
                  state_ff    <= FINISH;
               end
            end
            FINISH: begin
               if (commit) begin
                  rsp_valid_ff <= 1'b1;
                  status_ff    <= status_in;
                  found_map_ff <= found_map_in;
                  owner_id_ff  <= owner_id_in;
                  if (ins_ok && take_owner) begin
                     open_owner_ff <= next_owner_ff;
                     if (next_owner_ff == crt_pkg::OWNER_LAST) begin
                        next_owner_ff <= crt_pkg::OWNER_FIRST;
                     end else begin
                        next_owner_ff <= next_owner_ff + crt_pkg::OWNER_FIRST;
                     end
                  end
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.status    = status_ff;
   assign rsp_bus.found_map = found_map_ff;
   assign rsp_bus.owner_id  = owner_id_ff;

endmodule

// ===== rtl/crt_cell.sv =====
module crt_cell #(
   parameter int ADDR_BITS = 48,
   parameter int SLOT_BITS = 6,
   parameter int INDEX     = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  crt_pkg::tok_type      tok_in,
   input  logic [SLOT_BITS-1:0]  slot_in,
   output crt_pkg::tok_type      tok_out,
   output logic [SLOT_BITS-1:0]  slot_out,
   input  logic [ADDR_BITS-1:0]  key_addr,
   input  logic [ADDR_BITS-1:0]  key_end,
   input  crt_pkg::bcast_type    bcast,
   input  logic [SLOT_BITS-1:0]  wr_slot
);

   localparam logic [SLOT_BITS-1:0] MY_SLOT = SLOT_BITS'(INDEX);

   logic                            valid_ff;
   logic                            valid_in;
   logic [ADDR_BITS-1:0]            begin_ff;
   logic [ADDR_BITS-1:0]            end_ff;
   logic [crt_pkg::MAP_BITS-1:0]    map_ff;
   logic [crt_pkg::OWNER_BITS-1:0]  owner_ff;
   crt_pkg::tok_type                tok_ff;
   crt_pkg::tok_type                tok_in_next;
   logic [SLOT_BITS-1:0]            slot_ff;
   logic [SLOT_BITS-1:0]            slot_in_next;
   logic                            write_me;

   assign write_me = bcast.wr_en && (wr_slot == MY_SLOT);

   always_comb begin
      tok_in_next  = tok_in;
      slot_in_next = slot_in;
      valid_in     = valid_ff;
      if (tok_in.active) begin
         case (tok_in.cmd)
            crt_pkg::CMD_LOOKUP: begin
               if (!tok_in.hit && valid_ff && begin_ff <= key_addr && key_addr < end_ff) begin
                  tok_in_next.hit   = 1'b1;
                  tok_in_next.map   = map_ff;
                  tok_in_next.owner = owner_ff;
               end
            end
            crt_pkg::CMD_INSERT: begin
               if (valid_ff) begin
                  if (begin_ff < key_end && key_addr < end_ff) begin
                     tok_in_next.overlap = 1'b1;
                  end
               end else if (!tok_in.free_found) begin
                  tok_in_next.free_found = 1'b1;
                  slot_in_next           = MY_SLOT;
               end
            end
            crt_pkg::CMD_REMOVE: begin
               if (bcast.drop_en && valid_ff && owner_ff == bcast.drop_owner) begin
                  valid_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
      if (write_me) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         tok_ff.active <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in_next;
      end
      slot_ff <= slot_in_next;
      if (write_me) begin
         begin_ff <= key_addr;
         end_ff   <= key_end;
         map_ff   <= bcast.wr_map;
         owner_ff <= bcast.wr_owner;
      end
   end

   assign tok_out  = tok_ff;
   assign slot_out = slot_ff;

endmodule

// ===== verif/testbench.sv =====
module testbench;

   localparam int SLOTS          = 64;
   localparam int ADDR_W         = 48;
   localparam int RANDOM_BLOCKS  = 4;
   localparam int BLOCK_ITEMS    = 280;
   localparam int FILL_ITEMS     = 100;
   localparam int HOLD_CYCLES    = 400;
   localparam int CYCLE_LIMIT    = 600000;
   localparam logic [63:0] WINDOW_SPAN = 64'h4_0000;
   localparam logic [63:0] ADDR_MASK   = (64'd1 << ADDR_W) - 64'd1;
   localparam logic [ADDR_W-1:0] ADDR_TOP = '1;
   localparam logic [crt_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [crt_pkg::CMD_BITS-1:0]   cmd;
      logic [ADDR_W-1:0]              address;
      logic [crt_pkg::SIZE_BITS-1:0]  code_bytes;
      logic [crt_pkg::SIZE_BITS-1:0]  last_offset;
      logic                           has_records;
      logic                           group_start;
      logic [crt_pkg::MAP_BITS-1:0]   map_ref;
      logic [crt_pkg::OWNER_BITS-1:0] owner_to_drop;
   } req_item_type;

   typedef struct packed {
      logic [crt_pkg::STATUS_BITS-1:0] status;
      logic [crt_pkg::MAP_BITS-1:0]    found_map;
      logic [crt_pkg::OWNER_BITS-1:0]  owner_id;
   } rsp_item_type;

   typedef struct packed {
      logic [SLOTS-1:0]                           used;
      logic [SLOTS-1:0][ADDR_W-1:0]               lo;
      logic [SLOTS-1:0][ADDR_W-1:0]               hi;
      logic [SLOTS-1:0][crt_pkg::MAP_BITS-1:0]    map;
      logic [SLOTS-1:0][crt_pkg::OWNER_BITS-1:0]  owner;
      logic [crt_pkg::OWNER_BITS-1:0]             next_id;
      logic [crt_pkg::OWNER_BITS-1:0]             open_id;
   } range_state_type;

   logic clock = 1'b0;
   logic reset;

   crt_req_if #(.ADDR_BITS(ADDR_W)) req_bus ();
   crt_rsp_if rsp_bus ();

   code_range_table #(
      .TABLE_ENTRIES(SLOTS),
      .ADDRESS_BITS (ADDR_W)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   range_state_type plan_state;
   range_state_type check_state;
   req_item_type    pending_q[$];
   rsp_item_type    expected_q[$];
   rsp_item_type    want_rsp;
   int              item_total = 0;
   int              accepted_n = 0;
   int              fail_count = 0;
   int              cycle_n    = 0;
   int              hold_left  = 0;
   logic            hold_armed = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // next result of the range store, updating its state
   function automatic rsp_item_type range_outcome(inout range_state_type s,
                                                  input req_item_type q);
      rsp_item_type r;
      logic [63:0]  start;
      logic [63:0]  len;
      logic [63:0]  stop;
      int           slot;
      logic         found;
      logic         clash;
      r = '0;
      case (q.cmd)
         crt_pkg::CMD_LOOKUP: begin
            r.status = crt_pkg::ST_MISS;
            found = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
               if (!found && s.used[i] && s.lo[i] <= q.address && q.address < s.hi[i]) begin
                  found = 1'b1;
                  r.status = crt_pkg::ST_OK;
                  r.found_map = s.map[i];
                  r.owner_id = s.owner[i];
               end
            end
         end
         crt_pkg::CMD_INSERT: begin
            start = 64'(q.address);
            len = (q.code_bytes != '0) ? 64'(q.code_bytes) : 64'(q.last_offset) + 64'd1;
            if (start == 64'd0 || !q.has_records || len > ADDR_MASK - start) begin
               r.status = crt_pkg::ST_INVALID;
            end else begin
               stop = start + len;
               slot = -1;
               clash = 1'b0;
               for (int i = 0; i < SLOTS; i++) begin
                  if (s.used[i]) begin
                     if (64'(s.lo[i]) < stop && start < 64'(s.hi[i])) clash = 1'b1;
                  end else if (slot < 0) begin
                     slot = i;
                  end
               end
               if (clash) begin
                  r.status = crt_pkg::ST_OVERLAP;
               end else if (slot < 0) begin
                  r.status = crt_pkg::ST_FULL;
               end else begin
                  if (q.group_start || s.open_id == crt_pkg::OWNER_NONE) begin
                     s.open_id = s.next_id;
                     s.next_id = (s.next_id == crt_pkg::OWNER_LAST) ? crt_pkg::OWNER_FIRST
                                                                   : s.next_id + 1'b1;
                  end
                  s.used[slot] = 1'b1;
                  s.lo[slot] = start[ADDR_W-1:0];
                  s.hi[slot] = stop[ADDR_W-1:0];
                  s.map[slot] = q.map_ref;
                  s.owner[slot] = s.open_id;
                  r.status = crt_pkg::ST_OK;
                  r.owner_id = s.open_id;
               end
            end
         end
         crt_pkg::CMD_REMOVE: begin
            if (q.owner_to_drop != crt_pkg::OWNER_NONE) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (s.used[i] && s.owner[i] == q.owner_to_drop) s.used[i] = 1'b0;
               end
            end
            r.status = crt_pkg::ST_OK;
         end
         default: begin
            r.status = crt_pkg::ST_INVALID;
         end
      endcase
      return r;
   endfunction

   function automatic range_state_type empty_store();
      range_state_type s;
      s = '0;
      s.next_id = crt_pkg::OWNER_FIRST;
      s.open_id = crt_pkg::OWNER_NONE;
      return s;
   endfunction

   function automatic req_item_type make_item(logic [crt_pkg::CMD_BITS-1:0] cmd,
                                              logic [ADDR_W-1:0] address,
                                              logic [crt_pkg::SIZE_BITS-1:0] code_bytes,
                                              logic [crt_pkg::SIZE_BITS-1:0] last_offset,
                                              logic has_records, logic group_start,
                                              logic [crt_pkg::MAP_BITS-1:0] map_ref,
                                              logic [crt_pkg::OWNER_BITS-1:0] owner_to_drop);
      return '{cmd, address, code_bytes, last_offset, has_records, group_start, map_ref,
               owner_to_drop};
   endfunction

   // queues a command and tracks the store it will leave behind
   task automatic plan_item(input req_item_type it);
      void'(range_outcome(plan_state, it));
      pending_q = {pending_q, it};
   endtask

   function automatic int any_used_slot();
      int first;
      first = $urandom_range(SLOTS - 1);
      for (int n = 0; n < SLOTS; n++) begin
         if (plan_state.used[(first + n) % SLOTS]) return (first + n) % SLOTS;
      end
      return -1;
   endfunction

   function automatic int idle_pct(logic receiver);
      int phase;
      phase = (item_total == 0) ? 0 : accepted_n * 3 / item_total;
      case (phase)
         0:       return receiver ? 49 : 25;
         1:       return receiver ? 25 : 49;
         default: return 0;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("mismatch at cycle %0d: %s", cycle_n, msg);
   endtask

   // stimulus
   initial begin
      req_item_type   it;
      logic [159:0]   noise;
      logic [63:0]    len;
      logic [63:0]    span;
      logic [63:0]    cursor;
      logic [ADDR_W-1:0] win_base;
      logic [ADDR_W-1:0] a;
      int             pick;
      int             sub;
      int             j;
      int             insert_pct;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      {req_bus.cmd, req_bus.address, req_bus.code_bytes, req_bus.last_offset,
       req_bus.has_records, req_bus.group_start, req_bus.map_ref,
       req_bus.owner_to_drop} = '0;
      rsp_bus.ready = 1'b0;

      plan_state = empty_store();
      check_state = empty_store();

      a = 48'h0000_1000_0000;
      plan_item(make_item(crt_pkg::CMD_LOOKUP, '0, 0, 0, 1'b0, 1'b0, '0, '0));
      plan_item(make_item(crt_pkg::CMD_LOOKUP, ADDR_TOP, 0, 0, 1'b0, 1'b0, '0, '0));
      plan_item(make_item(crt_pkg::CMD_INSERT, '0, 16, 0, 1'b1, 1'b1, 16'h1234, '0));
      plan_item(make_item(crt_pkg::CMD_INSERT, a, 16, 0, 1'b0, 1'b1, 16'h1234, '0));
      plan_item(make_item(crt_pkg::CMD_INSERT, ADDR_TOP - 15, 32, 0, 1'b1, 1'b1, 16'h1234,
                          '0));
      // ends exactly at the top of the address space, no group open yet
      plan_item(make_item(crt_pkg::CMD_INSERT, ADDR_TOP - 16, 16, 0, 1'b1, 1'b0, 16'hFFFF,
                          '0));
      plan_item(make_item(crt_pkg::CMD_INSERT, a, 0, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'h0000,
                          '0));
      plan_item(make_item(crt_pkg::CMD_INSERT, a + 16, 1, 0, 1'b1, 1'b0, 16'h1111, '0));
      plan_item(make_item(crt_pkg::CMD_INSERT, a + 48'h1_0000_0000, 32'hFFFF_FFFF, 0, 1'b1,
                          1'b0, 16'h5A5A, '0));
      plan_item(make_item(crt_pkg::CMD_INSERT, a - 256, 256, 0, 1'b1, 1'b1, 16'h00FF, '0));
      plan_item(make_item(crt_pkg::CMD_LOOKUP, a, 0, 0, 1'b0, 1'b0, '0, '0));
      plan_item(make_item(crt_pkg::CMD_LOOKUP, a + 48'h0_FFFF_FFFF, 0, 0, 1'b0, 1'b0, '0,
                          '0));
      plan_item(make_item(crt_pkg::CMD_LOOKUP, a + 48'h1_0000_0000, 0, 0, 1'b0, 1'b0, '0,
                          '0));
      plan_item(make_item(crt_pkg::CMD_LOOKUP, a - 1, 0, 0, 1'b0, 1'b0, '0, '0));
      plan_item(make_item(crt_pkg::CMD_LOOKUP, ADDR_TOP - 1, 0, 0, 1'b0, 1'b0, '0, '0));
      plan_item(make_item(crt_pkg::CMD_LOOKUP, ADDR_TOP, 0, 0, 1'b0, 1'b0, '0, '0));
      plan_item(make_item(crt_pkg::CMD_REMOVE, '0, 0, 0, 1'b0, 1'b0, '0,
                          crt_pkg::OWNER_NONE));
      plan_item(make_item(CMD_UNUSED, a, 16, 0, 1'b1, 1'b1, 16'h2222, 16'd2));
      plan_item(make_item(crt_pkg::CMD_REMOVE, '0, 0, 0, 1'b0, 1'b0, '0, 16'd2));
      plan_item(make_item(crt_pkg::CMD_LOOKUP, a, 0, 0, 1'b0, 1'b0, '0, '0));
      // remove keeps the open group
      plan_item(make_item(crt_pkg::CMD_INSERT, a, 0, 0, 1'b1, 1'b0, 16'hA5A5, '0));
      plan_item(make_item(crt_pkg::CMD_LOOKUP, a, 0, 0, 1'b0, 1'b0, '0, '0));
      plan_item(make_item(crt_pkg::CMD_REMOVE, '0, 0, 0, 1'b0, 1'b0, '0, 16'd3));
      plan_item(make_item(crt_pkg::CMD_REMOVE, '0, 0, 0, 1'b0, 1'b0, '0, 16'd1));

      win_base = {1'b0, 15'($urandom_range(1, 32767)), 32'h0};
      cursor = 64'($urandom_range(0, 4095));
      for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
         for (int k = 0; k < BLOCK_ITEMS; k++) begin
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
            it = noise[$bits(req_item_type)-1:0];
            pick = $urandom_range(99);
            insert_pct = (k < FILL_ITEMS) ? 80 : 46;
            if (pick < insert_pct) begin
               it.cmd = crt_pkg::CMD_INSERT;
               it.has_records = 1'b1;
               it.group_start = ($urandom_range(5) == 0);
               sub = $urandom_range(99);
               if (sub < 68) begin
                  // fresh range above the last one, until the cursor passes WINDOW_SPAN and restarts low
                  it.address = win_base + cursor[ADDR_W-1:0];
                  if ($urandom_range(4) == 0) begin
                     it.code_bytes = '0;
                     it.last_offset = $urandom_range(0, 2047);
                     len = 64'(it.last_offset) + 64'd1;
                  end else begin
                     it.code_bytes = $urandom_range(1, 4096);
                     len = 64'(it.code_bytes);
                  end
                  cursor = cursor + len + 64'($urandom_range(0, 256));
                  if (cursor > WINDOW_SPAN) cursor = 64'($urandom_range(0, 4095));
               end else if (sub < 82) begin
                  j = any_used_slot();
                  if (j >= 0) begin
                     span = 64'(plan_state.hi[j]) - 64'(plan_state.lo[j]);
                     it.address = plan_state.lo[j] + ADDR_W'({$urandom, $urandom} % span)
                                  - ADDR_W'($urandom_range(0, 16));
                  end else begin
                     it.address = win_base + ADDR_W'($urandom % WINDOW_SPAN);
                  end
                  it.code_bytes = $urandom_range(1, 8192);
               end else if (sub < 89) begin
                  case ($urandom_range(2))
                     0: it.address = '0;
                     1: it.has_records = 1'b0;
                     default: begin
                        it.address = ADDR_TOP - ADDR_W'($urandom_range(0, 4095));
                        it.code_bytes = $urandom_range(1, 8192);
                     end
                  endcase
               end else if (sub < 95) begin
                  if ($urandom_range(1) == 0) it.code_bytes = '0;
               end else begin
                  it.address = win_base + ADDR_W'($urandom % WINDOW_SPAN);
                  it.code_bytes = $urandom_range(1, 2048);
               end
            end else if (pick < 94) begin
               it.cmd = crt_pkg::CMD_LOOKUP;
               j = any_used_slot();
               if (j >= 0 && $urandom_range(3) != 0) begin
                  span = 64'(plan_state.hi[j]) - 64'(plan_state.lo[j]);
                  case ($urandom_range(4))
                     0: it.address = plan_state.lo[j] - 1'b1;
                     1: it.address = plan_state.hi[j];
                     2: it.address = plan_state.hi[j] - 1'b1;
                     default: it.address = plan_state.lo[j]
                                           + ADDR_W'({$urandom, $urandom} % span);
                  endcase
               end else if ($urandom_range(1) == 0) begin
                  it.address = win_base + ADDR_W'($urandom % WINDOW_SPAN);
               end
            end else if (pick < 98) begin
               it.cmd = crt_pkg::CMD_REMOVE;
               j = any_used_slot();
               sub = $urandom_range(99);
               if (j >= 0 && sub < 80) it.owner_to_drop = plan_state.owner[j];
               else if (sub < 88) it.owner_to_drop = crt_pkg::OWNER_NONE;
               else if (sub < 94) it.owner_to_drop = plan_state.open_id;
            end else begin
               it.cmd = CMD_UNUSED;
            end
            plan_item(it);
         end
         // drop every owner left so the next block starts from an empty store
         while (plan_state.used != '0) begin
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
            it = noise[$bits(req_item_type)-1:0];
            it.cmd = crt_pkg::CMD_REMOVE;
            it.owner_to_drop = plan_state.owner[any_used_slot()];
            plan_item(it);
         end
      end
      item_total = pending_q.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clock);
      repeat (SLOTS + 8) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_q = {expected_q, range_outcome(check_state, pending_q.pop_front())};
            accepted_n <= accepted_n + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
               req_bus.valid <= 1'b1;
               {req_bus.cmd, req_bus.address, req_bus.code_bytes, req_bus.last_offset,
                req_bus.has_records, req_bus.group_start, req_bus.map_ref,
                req_bus.owner_to_drop} <= pending_q[0];
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // long result back-pressure late in the run
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_armed <= 1'b1;
      end else if (hold_armed && item_total != 0 && accepted_n >= item_total * 5 / 6) begin
         hold_left <= HOLD_CYCLES;
         hold_armed <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch($sformatf("result transfer with nothing expected, status %0d",
                                         rsp_bus.status));
            end else begin
               want_rsp = expected_q.pop_front();
               if (rsp_bus.status !== want_rsp.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_bus.status, want_rsp.status));
               if (rsp_bus.found_map !== want_rsp.found_map)
                  report_mismatch($sformatf("found_map got %0h want %0h",
                                            rsp_bus.found_map, want_rsp.found_map));
               if (rsp_bus.owner_id !== want_rsp.owner_id)
                  report_mismatch($sformatf("owner_id got %0h want %0h",
                                            rsp_bus.owner_id, want_rsp.owner_id));
            end
         end
         rsp_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b1));
      end
   end

   always @(posedge clock) begin
      cycle_n <= cycle_n + 1;
      if (cycle_n >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

endmodule

// ===== code_range_table.f =====
rtl/crt_pkg.sv
rtl/crt_ifs.sv
rtl/crt_cell.sv
rtl/code_range_table.sv
verif/testbench.sv
